[rtl/point_cloud_box_projection_filter_top_defines.svh]
// Assertion macros for the box projection filter modules.
// Each module that asserts includes this file; it needs clk and arst_n in scope.
`ifndef POINT_CLOUD_BOX_PROJECTION_FILTER_TOP_DEFINES_SVH
`define POINT_CLOUD_BOX_PROJECTION_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCBPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCBPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pcbpf_pkg.sv]
// Types and constants of the point cloud box projection filter.
// Used by every module of the block; depends on nothing.
package pcbpf_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_POINT  = 2'd2;
	localparam logic [1:0] CMD_END    = 2'd3;

	localparam logic [2:0] REG_FOCAL_X  = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_WIDTH    = 3'd4;
	localparam logic [2:0] REG_HEIGHT   = 3'd5;
	localparam logic [2:0] REG_RADIUS   = 3'd6;
	localparam logic [2:0] REG_MARGIN   = 3'd7;

	// Slot and box count fields sized for the largest table of 256 boxes.
	localparam int SLOT_W = 8;
	localparam int NBOX_W = 9;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;
	localparam int PIX_W = 13;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               finite;
		logic [11:0]        box_left;
		logic [11:0]        box_top;
		logic [11:0]        box_right;
		logic [11:0]        box_bottom;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [11:0]        pixel_u;
		logic [11:0]        pixel_v;
		logic               cloud_done;
		logic [23:0]        kept_count;
	} out_item_t;

	typedef struct packed {
		logic [31:0] focal_x;
		logic [31:0] focal_y;
		logic [31:0] center_x;
		logic [31:0] center_y;
		logic [12:0] img_width;
		logic [12:0] img_height;
		logic [31:0] max_radius;
		logic [7:0]  edge_margin;
	} cfg_t;

	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [11:0] right;
		logic [11:0] bottom;
	} box_t;

	typedef enum logic [1:0] {
		K_APPEND,
		K_POINT,
		K_END
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        x;
		logic [31:0]        y;
		logic [31:0]        z;
		box_t               box;
		logic [SLOT_W-1:0]  slot;
		logic [NBOX_W-1:0]  nbox;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_CHK,
		ST_DIV,
		ST_BND,
		ST_BRD,
		ST_BCMP
	} state_t;

endpackage

[rtl/pcbpf_front.sv]
// Front end: accepts input beats, tracks the box table's fill and fresh mark,
// and queues the jobs that the back end must carry out. Depends on pcbpf_pkg.
module pcbpf_front #(
	parameter int MAX_BOXES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pcbpf_pkg::in_item_t item,
	output logic                full,
	input  logic                q_full,
	output logic                q_wr,
	output pcbpf_pkg::job_t     q_data
);
	import pcbpf_pkg::*;

	localparam int CNT_W = $clog2(MAX_BOXES + 1);

	logic             fresh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             acc;

	assign full = q_full;
	assign acc  = push && !q_full;

	always_comb begin
		q_data.kind = K_POINT;
		q_data.x    = item.pos_x;
		q_data.y    = item.pos_y;
		q_data.z    = item.pos_z;
		q_data.box  = '{item.box_left, item.box_top, item.box_right, item.box_bottom};
		q_data.slot = SLOT_W'(cnt_q);
		q_data.nbox = NBOX_W'(cnt_q);
		q_wr        = 1'b0;
		unique case (item.cmd)
			CMD_CLEAR: begin
				q_wr = 1'b0;
			end
			CMD_APPEND: begin
				q_data.kind = K_APPEND;
				q_wr = acc && (cnt_q < CNT_W'(MAX_BOXES));
			end
			CMD_POINT: begin
				q_data.kind = K_POINT;
				q_wr = acc && fresh_q && (cnt_q != '0) && item.finite;
			end
			CMD_END: begin
				q_data.kind = K_END;
				q_wr = acc;
			end
			default: q_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b0;
			cnt_q   <= '0;
		end else if (acc) begin
			case (item.cmd)
				CMD_CLEAR: begin
					fresh_q <= 1'b1;
					cnt_q   <= '0;
				end
				CMD_APPEND: begin
					if (cnt_q < CNT_W'(MAX_BOXES)) cnt_q <= cnt_q + 1'b1;
				end
				CMD_END: fresh_q <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule

[rtl/pcbpf_fifo.sv]
// Short job queue between the front and back ends.
// Depends on pcbpf_pkg for the job type and depth.
module pcbpf_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  pcbpf_pkg::job_t wr_data,
	output logic            full,
	input  logic            rd,
	output pcbpf_pkg::job_t rd_data,
	output logic            empty
);
	import pcbpf_pkg::*;

	job_t                  slots_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wp_q, rp_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = slots_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) slots_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 1'b1;
			if (rd && !empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + FIFO_CNT_W'(wr && !full) - FIFO_CNT_W'(rd && !empty);
		end
	end

endmodule

[rtl/pcbpf_back.sv]
// Back end: stores boxes, screens and projects points with an iterative divider,
// scans the box table and holds one result beat. Depends on pcbpf_pkg.
module pcbpf_back #(
	parameter int MAX_BOXES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcbpf_pkg::cfg_t      cfg,
	input  logic                 q_empty,
	input  pcbpf_pkg::job_t      q_data,
	output logic                 q_rd,
	output logic                 empty,
	input  logic                 pop,
	output pcbpf_pkg::out_item_t result
);
	import pcbpf_pkg::*;

	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	state_t st_q, st_nx;

	box_t             boxes [MAX_BOXES];
	box_t             rdata_q;
	logic [IDX_W-1:0] box_idx_q;
	logic [NBOX_W-1:0] nbox_q;

	logic [31:0] x_q, y_q, z_q;
	logic [63:0] ax_q, bx_q, ay_q, by_q, sx_q, sy_q, sz_q, r2_q;
	logic [64:0] d2_q;
	logic [63:0] nx_q, ny_q, dfx_q, dfy_q;
	logic        gtx_q, gty_q;
	logic [63:0] remx_q, remy_q, dsh_q;
	logic [PIX_W-1:0] ux_q, vy_q;
	logic [3:0]  bit_q;

	logic        res_valid_q;
	out_item_t   res_q;
	logic [23:0] kept_q;

	logic        take, chk_rej, bnd_rej, hit, last_box;
	logic [31:0] mx, my, mz;
	logic [63:0] dz, dz13;
	logic signed [PIX_W:0] limx, limy;

	assign empty  = !res_valid_q;
	assign result = res_q;

	assign mx = x_q[31] ? (~x_q + 32'd1) : x_q;
	assign my = y_q[31] ? (~y_q + 32'd1) : y_q;
	assign mz = z_q[31] ? (~z_q + 32'd1) : z_q;

	// Divisor is z in Q15.16 scaled once more by 2^16.
	assign dz   = {16'd0, z_q, 16'd0};
	assign dz13 = {4'd0, z_q[30:0], 29'd0};

	// A numerator at or above the divisor times 2^13 gives a pixel beyond any image.
	assign chk_rej = (d2_q > {1'b0, r2_q}) || z_q[31] || (z_q == '0)
		|| (x_q[31] && gtx_q && (dfx_q >= dz))
		|| (y_q[31] && gty_q && (dfy_q >= dz))
		|| (nx_q >= dz13) || (ny_q >= dz13);

	assign limx = $signed({1'b0, cfg.img_width}) - $signed({6'd0, cfg.edge_margin});
	assign limy = $signed({1'b0, cfg.img_height}) - $signed({6'd0, cfg.edge_margin});
	assign bnd_rej = (ux_q < PIX_W'(cfg.edge_margin)) || (vy_q < PIX_W'(cfg.edge_margin))
		|| ($signed({1'b0, ux_q}) >= limx) || ($signed({1'b0, vy_q}) >= limy);

	assign hit = ({1'b0, rdata_q.left} <= ux_q) && (ux_q <= {1'b0, rdata_q.right})
		&& ({1'b0, rdata_q.top} <= vy_q) && (vy_q <= {1'b0, rdata_q.bottom});
	assign last_box = ((NBOX_W'(box_idx_q) + 1'b1) == nbox_q);

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE: if (take && q_data.kind == K_POINT) st_nx = ST_MUL;
			ST_MUL:  st_nx = ST_SUM;
			ST_SUM:  st_nx = ST_CHK;
			ST_CHK:  st_nx = chk_rej ? ST_IDLE : ST_DIV;
			ST_DIV:  if (bit_q == '0) st_nx = ST_BND;
			ST_BND:  st_nx = bnd_rej ? ST_IDLE : ST_BRD;
			ST_BRD:  st_nx = ST_BCMP;
			ST_BCMP: st_nx = (hit || last_box) ? ST_IDLE : ST_BRD;
			default: st_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		take = (st_q == ST_IDLE) && !q_empty && !res_valid_q;
		q_rd = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_nx;
	end

	// Box table: one write port from the queue head, one registered read port.
	always_ff @(posedge clk) begin
		if (take && q_data.kind == K_APPEND) boxes[q_data.slot[IDX_W-1:0]] <= q_data.box;
		rdata_q <= boxes[box_idx_q];
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q    <= q_data.x;
				y_q    <= q_data.y;
				z_q    <= q_data.z;
				nbox_q <= q_data.nbox;
			end
			ST_MUL: begin
				ax_q <= 64'(mx) * 64'(cfg.focal_x);
				bx_q <= 64'(z_q) * 64'(cfg.center_x);
				ay_q <= 64'(my) * 64'(cfg.focal_y);
				by_q <= 64'(z_q) * 64'(cfg.center_y);
				sx_q <= 64'(mx) * 64'(mx);
				sy_q <= 64'(my) * 64'(my);
				sz_q <= 64'(mz) * 64'(mz);
				r2_q <= 64'(cfg.max_radius) * 64'(cfg.max_radius);
			end
			ST_SUM: begin
				d2_q  <= 65'(sx_q) + 65'(sy_q) + 65'(sz_q);
				gtx_q <= ax_q > bx_q;
				gty_q <= ay_q > by_q;
				dfx_q <= ax_q - bx_q;
				dfy_q <= ay_q - by_q;
				// A negative offset smaller than one pixel truncates to column or row zero.
				nx_q  <= !x_q[31] ? ax_q + bx_q : ((bx_q >= ax_q) ? bx_q - ax_q : '0);
				ny_q  <= !y_q[31] ? ay_q + by_q : ((by_q >= ay_q) ? by_q - ay_q : '0);
			end
			ST_CHK: begin
				remx_q <= nx_q;
				remy_q <= ny_q;
				// The divisor starts aligned with the top quotient bit.
				dsh_q  <= {4'd0, z_q[31:0], 28'd0};
				bit_q  <= 4'(PIX_W - 1);
				ux_q   <= '0;
				vy_q   <= '0;
			end
			ST_DIV: begin
				if (remx_q >= dsh_q) begin
					remx_q <= remx_q - dsh_q;
					ux_q   <= {ux_q[PIX_W-2:0], 1'b1};
				end else begin
					ux_q <= {ux_q[PIX_W-2:0], 1'b0};
				end
				if (remy_q >= dsh_q) begin
					remy_q <= remy_q - dsh_q;
					vy_q   <= {vy_q[PIX_W-2:0], 1'b1};
				end else begin
					vy_q <= {vy_q[PIX_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				bit_q <= bit_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
			kept_q      <= '0;
			box_idx_q   <= '0;
		end else begin
			if (pop && res_valid_q) res_valid_q <= 1'b0;
			if (st_q == ST_BND) box_idx_q <= '0;
			if (st_q == ST_BCMP && !hit && !last_box) box_idx_q <= box_idx_q + 1'b1;
			if (take && q_data.kind == K_END) begin
				res_valid_q      <= 1'b1;
				res_q            <= '0;
				res_q.cloud_done <= 1'b1;
				res_q.kept_count <= kept_q;
				kept_q           <= '0;
			end
			if (st_q == ST_BCMP && hit) begin
				res_valid_q      <= 1'b1;
				res_q.out_x      <= x_q;
				res_q.out_y      <= y_q;
				res_q.out_z      <= z_q;
				res_q.pixel_u    <= ux_q[11:0];
				res_q.pixel_v    <= vy_q[11:0];
				res_q.cloud_done <= 1'b0;
				res_q.kept_count <= '0;
				if (kept_q != '1) kept_q <= kept_q + 1'b1;
			end
		end
	end

`include "point_cloud_box_projection_filter_top_defines.svh"

	`PCBPF_ASSERT_IMP(a_scan_in_range, st_q == ST_BCMP, NBOX_W'(box_idx_q) < nbox_q, "box scan past table fill")
	`PCBPF_ASSERT_IMP(a_report_clean, res_valid_q && res_q.cloud_done, res_q.pixel_u == '0 && res_q.pixel_v == '0, "cloud report carries pixel data")
	`PCBPF_ASSERT_NXT(a_no_take_while_busy, st_q != ST_IDLE, !take || st_q == ST_IDLE, "queue read outside idle state")

endmodule

[rtl/point_cloud_box_projection_filter_top.sv]
// Point cloud box projection filter: one point, box or end-of-cloud beat per job.
// Append and end jobs are taken in the back end's idle state, which takes a job only while
// no result is held. A point runs MUL, SUM and CHK, where the radius, depth or range check
// may drop it, then DIV (13-step divider), BND (edge test) and BRD, BCMP per box examined
// (one-port table scan). A 4-deep job queue buffers input.
// Reset (arst_n low) empties the queues, clears counts and fresh mark, loads defaults.
module point_cloud_box_projection_filter_top #(
	parameter int MAX_BOXES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pcbpf_pkg::in_item_t  item,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output pcbpf_pkg::out_item_t result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  logic [31:0]          cfg_data
);
	import pcbpf_pkg::*;

	cfg_t cfg_q;
	job_t wr_job, rd_job;
	logic q_wr, q_full, q_rd, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x     <= 32'd39321600;
			cfg_q.focal_y     <= 32'd39321600;
			cfg_q.center_x    <= 32'd20971520;
			cfg_q.center_y    <= 32'd15728640;
			cfg_q.img_width   <= 13'd640;
			cfg_q.img_height  <= 13'd480;
			cfg_q.max_radius  <= 32'd65536;
			cfg_q.edge_margin <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FOCAL_X:  cfg_q.focal_x     <= cfg_data;
				REG_FOCAL_Y:  cfg_q.focal_y     <= cfg_data;
				REG_CENTER_X: cfg_q.center_x    <= cfg_data;
				REG_CENTER_Y: cfg_q.center_y    <= cfg_data;
				REG_WIDTH:    cfg_q.img_width   <= cfg_data[12:0];
				REG_HEIGHT:   cfg_q.img_height  <= cfg_data[12:0];
				REG_RADIUS:   cfg_q.max_radius  <= cfg_data;
				REG_MARGIN:   cfg_q.edge_margin <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	pcbpf_front #(.MAX_BOXES(MAX_BOXES)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_data (wr_job)
	);

	pcbpf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (wr_job),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (rd_job),
		.empty   (q_empty)
	);

	pcbpf_back #(.MAX_BOXES(MAX_BOXES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (rd_job),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
